// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 16;
    localparam int COUNT_OUT_W = 5;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } spq_status_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } spq_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted queue: holds a value and its priority.
// Depends on spq_pkg.
`default_nettype none

module spq_cell
(
    input  wire logic                                clk,
    input  wire spq_pkg::spq_ctrl_t                  ctrl,
    input  wire logic                                occupied,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  new_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   new_prio,
    input  wire logic                                left_flag,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  left_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   left_prio,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  right_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   right_prio,
    output logic                                     flag,
    output logic signed [spq_pkg::VALUE_W-1:0]       value,
    output logic signed [spq_pkg::PRIO_W-1:0]        prio
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg, value_next;
    logic signed [spq_pkg::PRIO_W-1:0]  prio_reg, prio_next;

    // Entry stays ahead of the new item (ties keep arrival order)
    assign flag  = occupied && (prio_reg <= new_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.enq && !flag)
        begin
            if (left_flag)
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            else
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
        else if (ctrl.deq)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a row of spq_cell slots plus count.
// Depends on spq_pkg and spq_cell.
`default_nettype none

// Takes one enqueue or dequeue transaction per clock: busy never rises, and
// the result of a transaction accepted on one edge is presented with done
// for exactly one cycle after it, so a new transaction may be issued every
// cycle. Insertion is done by all slots comparing the new priority in the
// same cycle and shifting one place, so the time taken does not depend on the
// fill level. The receiver cannot stall: done is not held, capture it when
// it is high. head_value, head_valid and entry_count reflect the queue after
// the reported transaction. Equal priorities leave in arrival order.
module sorted_priority_queue
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                action,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    output logic                                     busy,
    output logic                                     done,
    output logic signed [spq_pkg::VALUE_W-1:0]       removed_value,
    output logic [1:0]                               status,
    output logic signed [spq_pkg::VALUE_W-1:0]       head_value,
    output logic                                     head_valid,
    output logic [spq_pkg::COUNT_OUT_W-1:0]          entry_count
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;

    logic [spq_pkg::CNT_W-1:0]           count_reg, count_next;
    logic                                done_reg;
    logic signed [spq_pkg::VALUE_W-1:0]  removed_reg, removed_next;
    spq_pkg::spq_status_t                status_reg, status_next;

    logic                                accept, full, empty;
    spq_pkg::spq_ctrl_t                  ctrl;

    logic                                cell_flag  [DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0]  cell_value [DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0]   cell_prio  [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == spq_pkg::CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        ctrl.enq     = accept && (action == spq_pkg::ACT_ENQ) && !full;
        ctrl.deq     = accept && (action == spq_pkg::ACT_DEQ) && !empty;
        count_next   = count_reg;
        removed_next = '0;
        status_next  = spq_pkg::ST_OK;
        if (ctrl.enq)
            count_next = count_reg + 1'b1;
        else if (ctrl.deq)
        begin
            count_next   = count_reg - 1'b1;
            removed_next = cell_value[0];
        end
        if (accept && (action == spq_pkg::ACT_ENQ) && full)
            status_next = spq_pkg::ST_OVER;
        else if (accept && (action == spq_pkg::ACT_DEQ) && empty)
            status_next = spq_pkg::ST_UNDER;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                                left_flag_w;
            logic signed [spq_pkg::VALUE_W-1:0]  left_value_w, right_value_w;
            logic signed [spq_pkg::PRIO_W-1:0]   left_prio_w, right_prio_w;
            logic                                occupied_w;

            assign occupied_w = (spq_pkg::CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_flag_w  = 1'b1;
                assign left_value_w = item_value;
                assign left_prio_w  = item_priority;
            end
            else
            begin : g_mid
                assign left_flag_w  = cell_flag[i-1];
                assign left_value_w = cell_value[i-1];
                assign left_prio_w  = cell_prio[i-1];
            end

            // Last slot refills from itself; it is beyond the count after a pop
            if (i == DEPTH - 1)
            begin : g_last
                assign right_value_w = cell_value[i];
                assign right_prio_w  = cell_prio[i];
            end
            else
            begin : g_inner
                assign right_value_w = cell_value[i+1];
                assign right_prio_w  = cell_prio[i+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied_w),
                .new_value   (item_value),
                .new_prio    (item_priority),
                .left_flag   (left_flag_w),
                .left_value  (left_value_w),
                .left_prio   (left_prio_w),
                .right_value (right_value_w),
                .right_prio  (right_prio_w),
                .flag        (cell_flag[i]),
                .value       (cell_value[i]),
                .prio        (cell_prio[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= spq_pkg::ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
    end

    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign head_valid    = !empty;
    assign head_value    = empty ? '0 : cell_value[0];
    assign entry_count   = spq_pkg::COUNT_OUT_W'(count_reg);

endmodule

`default_nettype wire
